@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define MSHL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define MSHL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/mshl_pkg.sv @@
package mshl_pkg;

    localparam int SCORE_W  = 24;
    localparam int LABEL_W  = 8;
    localparam int MARGIN_W = 23;
    localparam int LOSS_W   = 25;
    // Signed width of margin - score + score before clamping.
    localparam int SUM_W    = LOSS_W + 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic                      last;
        logic [LABEL_W-1:0]        predicted_label;
        logic [LABEL_W-1:0]        label;
        logic signed [SCORE_W-1:0] score;
    } item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] decrease_class;
        logic [LABEL_W-1:0] increase_class;
        logic               update_needed;
        logic [LOSS_W-1:0]  loss_value;
    } result_t;

endpackage

@@ rtl/max_score_hinge_loss.sv @@
// Multiclass max-score hinge loss over a stream of class scores.
// Input channel (s_): one transaction per class score, classes in ascending
// order; s_tlast marks the final class of a sample. Label and predicted label
// are taken from the first transaction of each sample only.
// Result channel (m_): one transaction per sample, issued for the s_tlast
// transaction; no transaction for the other classes.
// Configuration channel (cfg_): write the margin (unsigned Q11.12) while the
// block is idle; cfg_ready is always high.
// Path: an accepted s_tlast transaction waits in the input register; the running
// max compare and margin add then feed the result register, where m_tvalid
// rises. The final score waits while the result register is still held.
// Throughput: one class score per cycle, held only while a final score meets a
// full result register; the logic between the two registers sets that figure.
// Reset (aresetn low, synchronous): empty both registers, clear the running
// sample state and restore the margin to 1.0.
// Stall: while m_tready is low a held result stays put; class scores that are
// not the last of a sample keep flowing, and a final score waits in the input
// register until the result register frees up.
module max_score_hinge_loss #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // score [23:0], label [31:24], predicted_label [39:32]
    input  logic [mshl_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // loss_value [24:0], increase_class [32:25], decrease_class [40:33]
    output logic [mshl_pkg::M_TDATA_W-1:0]       m_tdata,
    // update_needed [0]
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mshl_pkg::MARGIN_W-1:0]        cfg_data
);

    localparam logic [mshl_pkg::MARGIN_W-1:0] MARGIN_RESET = 23'd4096;

    logic [mshl_pkg::MARGIN_W-1:0] margin_reg, margin_next;

    logic              item_valid;
    mshl_pkg::item_t   item;
    logic              take;
    logic              out_free;
    logic              res_load;
    mshl_pkg::result_t res_comb;
    mshl_pkg::result_t res_out;
    logic              last_stuck;

    // Margin register: accept every configuration transaction.
    assign cfg_ready   = 1'b1;
    assign margin_next = (cfg_valid && cfg_ready) ? cfg_data : margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
        end else begin
            margin_reg <= margin_next;
        end
    end

    // Advance an item out of the input register; hold a final item until
    // the result register can take its result.
    assign take     = item_valid && (!item.last || out_free);
    assign res_load = take && item.last;

    mshl_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mshl_accum #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .margin  (margin_reg),
        .res     (res_comb)
    );

    mshl_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res_in   (res_comb),
        .m_tready (m_tready),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .res_out  (res_out)
    );

    // Pack the result; pad the upper bits with zeros.
    assign m_tdata = {7'b0000000, res_out.decrease_class, res_out.increase_class,
                      res_out.loss_value};
    assign m_tuser = res_out.update_needed;

    // A final score sitting in the input register behind a full result register.
    assign last_stuck = item_valid && item.last && !out_free;

`include "assert_macros.svh"

    // A final score blocked by a stalled result must stay in the input register.
    `MSHL_ASSERT_NXT(a_last_held, aclk, aresetn, last_stuck, item_valid && $stable(item))

    // An update flag goes with a non-zero loss, and the reverse.
    `MSHL_ASSERT_IMP(a_update_loss, aclk, aresetn, m_tvalid, m_tuser[0] == (m_tdata[24:0] != 25'd0))

    // Without an update both gradient class fields read zero.
    `MSHL_ASSERT_IMP(a_no_update_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[40:25] == 16'd0)

endmodule

@@ rtl/mshl_in_stage.sv @@
module mshl_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // score [23:0], label [31:24], predicted_label [39:32]
    input  logic [mshl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            take,
    output logic                            item_valid,
    output mshl_pkg::item_t                 item
);

    logic            valid_reg;
    logic            valid_next;
    mshl_pkg::item_t item_reg;
    logic            load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: capture on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.score           <= s_tdata[23:0];
            item_reg.label           <= s_tdata[31:24];
            item_reg.predicted_label <= s_tdata[39:32];
            item_reg.last            <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/mshl_accum.sv @@
module mshl_accum #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              take,
    input  mshl_pkg::item_t                   item,
    input  logic [mshl_pkg::MARGIN_W-1:0]     margin,
    output mshl_pkg::result_t                 res
);

    localparam int CNT_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CLASSES - 1);

    localparam int SW = mshl_pkg::SCORE_W;
    localparam int LW = mshl_pkg::LABEL_W;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 full_reg, full_next;
    logic [LW-1:0]        lab_reg, lab_next;
    logic [LW-1:0]        pred_reg, pred_next;
    logic signed [SW-1:0] lab_sc_reg, lab_sc_next;
    logic signed [SW-1:0] pred_sc_reg, pred_sc_next;
    logic signed [SW-1:0] riv_sc_reg, riv_sc_next;
    logic [LW-1:0]        riv_idx_reg, riv_idx_next;
    logic                 riv_found_reg, riv_found_next;

    // Values after this item, before any end-of-sample clear.
    logic [CNT_W-1:0]     cnt_upd;
    logic                 full_upd;
    logic [LW-1:0]        lab_upd, pred_upd, riv_idx_upd;
    logic signed [SW-1:0] lab_sc_upd, pred_sc_upd, riv_sc_upd;
    logic                 riv_found_upd;
    logic [LW-1:0]        idx;

    logic [LW-1:0]                    rival;
    logic signed [SW-1:0]             rscore;
    logic signed [mshl_pkg::SUM_W-1:0] sum;
    logic                             positive;

    assign idx = LW'(cnt_reg);

    always_comb begin
        cnt_upd       = cnt_reg;
        full_upd      = full_reg;
        lab_upd       = lab_reg;
        pred_upd      = pred_reg;
        lab_sc_upd    = lab_sc_reg;
        pred_sc_upd   = pred_sc_reg;
        riv_sc_upd    = riv_sc_reg;
        riv_idx_upd   = riv_idx_reg;
        riv_found_upd = riv_found_reg;
        if (!full_reg) begin
            // Latch the labels from the first class of the sample.
            if (cnt_reg == '0) begin
                lab_upd  = item.label;
                pred_upd = item.predicted_label;
            end
            if (idx == lab_upd) begin
                lab_sc_upd = item.score;
            end else if (!riv_found_reg || (item.score > riv_sc_reg)) begin
                riv_sc_upd    = item.score;
                riv_idx_upd   = idx;
                riv_found_upd = 1'b1;
            end
            if (idx == pred_upd) begin
                pred_sc_upd = item.score;
            end
            if (cnt_reg == CNT_LAST) begin
                full_upd = 1'b1;
            end else begin
                cnt_upd = cnt_reg + 1'b1;
            end
        end
    end

    // Rival and loss from the updated state.
    always_comb begin
        priority if (lab_upd != pred_upd) begin
            rival  = pred_upd;
            rscore = pred_sc_upd;
        end else if (riv_found_upd) begin
            rival  = riv_idx_upd;
            rscore = riv_sc_upd;
        end else begin
            rival  = lab_upd;
            rscore = lab_sc_upd;
        end
        sum = $signed({3'b000, margin})
            - $signed({{2{lab_sc_upd[SW-1]}}, lab_sc_upd})
            + $signed({{2{rscore[SW-1]}}, rscore});
        positive = !sum[mshl_pkg::SUM_W-1] && (sum != '0);
        res.loss_value     = positive ? sum[mshl_pkg::LOSS_W-1:0] : '0;
        res.update_needed  = positive;
        res.increase_class = positive ? rival : '0;
        res.decrease_class = positive ? lab_upd : '0;
    end

    always_comb begin
        cnt_next       = cnt_reg;
        full_next      = full_reg;
        lab_next       = lab_reg;
        pred_next      = pred_reg;
        lab_sc_next    = lab_sc_reg;
        pred_sc_next   = pred_sc_reg;
        riv_sc_next    = riv_sc_reg;
        riv_idx_next   = riv_idx_reg;
        riv_found_next = riv_found_reg;
        if (take) begin
            lab_next  = lab_upd;
            pred_next = pred_upd;
            if (item.last) begin
                // Clear for the next sample; labels are kept.
                cnt_next       = '0;
                full_next      = 1'b0;
                lab_sc_next    = '0;
                pred_sc_next   = '0;
                riv_sc_next    = '0;
                riv_idx_next   = '0;
                riv_found_next = 1'b0;
            end else begin
                cnt_next       = cnt_upd;
                full_next      = full_upd;
                lab_sc_next    = lab_sc_upd;
                pred_sc_next   = pred_sc_upd;
                riv_sc_next    = riv_sc_upd;
                riv_idx_next   = riv_idx_upd;
                riv_found_next = riv_found_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            full_reg      <= 1'b0;
            lab_reg       <= '0;
            pred_reg      <= '0;
            lab_sc_reg    <= '0;
            pred_sc_reg   <= '0;
            riv_sc_reg    <= '0;
            riv_idx_reg   <= '0;
            riv_found_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            full_reg      <= full_next;
            lab_reg       <= lab_next;
            pred_reg      <= pred_next;
            lab_sc_reg    <= lab_sc_next;
            pred_sc_reg   <= pred_sc_next;
            riv_sc_reg    <= riv_sc_next;
            riv_idx_reg   <= riv_idx_next;
            riv_found_reg <= riv_found_next;
        end
    end

endmodule

@@ rtl/mshl_out_stage.sv @@
module mshl_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mshl_pkg::result_t res_in,
    input  logic              m_tready,
    output logic              out_free,
    output logic              m_tvalid,
    output mshl_pkg::result_t res_out
);

    logic              valid_reg, valid_next;
    mshl_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule
